// ----- sv/ltt_pkg.sv -----
package ltt_pkg;

    // Widths of the result fields, fixed by the token format.
    localparam int KIND_W   = 5;
    localparam int START_W  = 16;
    localparam int LENGTH_W = 7;

    // Default width of the running byte position.
    localparam int POSITION_BITS_DEFAULT = 16;

    // Identifier length saturates here; only the first bytes are kept for keywords.
    localparam int MAX_IDENT_LENGTH   = 127;
    localparam int IDENT_PREFIX_BYTES = 5;
    localparam int PREFIX_W           = 8 * IDENT_PREFIX_BYTES;

    // Entries in the queue between the scanner and the token sender.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        K_EOF    = 5'd0,
        K_LAMBDA = 5'd1,
        K_PI     = 5'd2,
        K_STAR   = 5'd3,
        K_BOX    = 5'd4,
        K_ARROW  = 5'd5,
        K_DOT    = 5'd6,
        K_COLON  = 5'd7,
        K_LPAREN = 5'd8,
        K_RPAREN = 5'd9,
        K_TRUE   = 5'd10,
        K_FALSE  = 5'd11,
        K_BOOL   = 5'd12,
        K_IF     = 5'd13,
        K_THEN   = 5'd14,
        K_ELSE   = 5'd15,
        K_IDENT  = 5'd16,
        K_ERROR  = 5'd17
    } token_kind_t;

    // Scanner modes, one-hot.
    typedef enum logic [8:0] {
        M_IDLE   = 9'b000000001,
        M_IDENT  = 9'b000000010,
        M_CE     = 9'b000000100,
        M_E2     = 9'b000001000,
        M_E2_98  = 9'b000010000,
        M_E2_96  = 9'b000100000,
        M_E2_86  = 9'b001000000,
        M_DASH   = 9'b010000000,
        M_ERROR  = 9'b100000000
    } scan_mode_t;

    // Byte codes the scanner looks for.
    localparam logic [7:0] B_CE        = 8'hCE;
    localparam logic [7:0] B_BB        = 8'hBB;
    localparam logic [7:0] B_A0        = 8'hA0;
    localparam logic [7:0] B_E2        = 8'hE2;
    localparam logic [7:0] B_98        = 8'h98;
    localparam logic [7:0] B_85        = 8'h85;
    localparam logic [7:0] B_96        = 8'h96;
    localparam logic [7:0] B_A1        = 8'hA1;
    localparam logic [7:0] B_86        = 8'h86;
    localparam logic [7:0] B_92        = 8'h92;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_QUOTE    = 8'h27;

    // Keyword prefixes packed first byte lowest; their lengths are checked in keyword_kind.
    localparam logic [PREFIX_W-1:0] W_TRUE  = 40'h0065757274;
    localparam logic [PREFIX_W-1:0] W_FALSE = 40'h65736C6166;
    localparam logic [PREFIX_W-1:0] W_BOOL  = 40'h006C6F6F42;
    localparam logic [PREFIX_W-1:0] W_IF    = 40'h0000006669;
    localparam logic [PREFIX_W-1:0] W_THEN  = 40'h006E656874;
    localparam logic [PREFIX_W-1:0] W_ELSE  = 40'h0065736C65;
    localparam logic [PREFIX_W-1:0] W_PI    = 40'h0000006950;
    localparam logic [PREFIX_W-1:0] W_BOXU  = 40'h0000584F42;
    localparam logic [PREFIX_W-1:0] W_BOXL  = 40'h0000786F42;

    typedef struct packed {
        token_kind_t               kind;
        logic [START_W-1:0]        start;
        logic [LENGTH_W-1:0]       length;
    } token_t;

    // All tokens caused by one input byte; the last one closes the run.
    typedef struct packed {
        token_t first;
        token_t second;
        logic   two;
    } token_run_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]});
    endfunction

    function automatic logic is_ident_more(input logic [7:0] b);
        return is_alpha(b) || (b inside {[8'h30:8'h39]}) || (b == CH_UNDER)
            || (b == CH_QUOTE);
    endfunction

    // Keyword lookup over the kept prefix and the saturated length.
    function automatic token_kind_t keyword_kind(input logic [PREFIX_W-1:0] prefix,
                                                 input logic [LENGTH_W-1:0] count);
        token_kind_t k;
        k = K_IDENT;
        if (count == 7'd4 && prefix == W_TRUE) k = K_TRUE;
        else if (count == 7'd5 && prefix == W_FALSE) k = K_FALSE;
        else if (count == 7'd4 && prefix == W_BOOL) k = K_BOOL;
        else if (count == 7'd2 && prefix == W_IF) k = K_IF;
        else if (count == 7'd4 && prefix == W_THEN) k = K_THEN;
        else if (count == 7'd4 && prefix == W_ELSE) k = K_ELSE;
        else if (count == 7'd2 && prefix == W_PI) k = K_PI;
        else if (count == 7'd3 && (prefix == W_BOXU || prefix == W_BOXL)) k = K_BOX;
        return k;
    endfunction

endpackage

// ----- sv/ltt_text_if.sv -----
interface ltt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- sv/ltt_token_if.sv -----
interface ltt_token_if;
    logic                          valid;
    logic                          ready;
    logic [ltt_pkg::KIND_W-1:0]    token_kind;
    logic [ltt_pkg::START_W-1:0]   token_start;
    logic [ltt_pkg::LENGTH_W-1:0]  token_length;
    logic                          last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

// ----- sv/ltt_front.sv -----
module ltt_front #(
    parameter int POSITION_BITS = ltt_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    ltt_text_if.sink            text,
    input  logic                queue_full,
    output logic                push,
    output ltt_pkg::token_run_t push_run
);

    ltt_pkg::scan_mode_t                 mode_reg, mode_next;
    logic [POSITION_BITS-1:0]            pos_reg, pos_next;
    logic [POSITION_BITS-1:0]            begin_reg, begin_next;
    logic [ltt_pkg::LENGTH_W-1:0]        count_reg, count_next;
    logic [ltt_pkg::PREFIX_W-1:0]        prefix_reg, prefix_next;

    logic                  fire;
    logic                  at_end;
    logic [7:0]            b;
    logic                  do_fresh;
    logic                  fr_emit;
    ltt_pkg::token_kind_t  fr_kind;
    ltt_pkg::scan_mode_t   fr_mode;
    logic                  has_a, has_b;
    ltt_pkg::token_t       tok_a, tok_b;

    function automatic logic [ltt_pkg::START_W-1:0] to_start(
        input logic [POSITION_BITS-1:0] p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[ltt_pkg::START_W-1:0];
    endfunction

    function automatic ltt_pkg::token_t mk_tok(input ltt_pkg::token_kind_t k,
                                               input logic [POSITION_BITS-1:0] p,
                                               input logic [ltt_pkg::LENGTH_W-1:0] len);
        ltt_pkg::token_t t;
        t.kind   = k;
        t.start  = to_start(p);
        t.length = len;
        return t;
    endfunction

    assign text.ready = !queue_full;
    assign fire       = text.valid && !queue_full;
    assign b          = text.text_byte;
    assign at_end     = text.end_of_text || (b == 8'd0);

    // Classification of a byte that starts a new token.
    always_comb
    begin
        fr_emit = 1'b0;
        fr_kind = ltt_pkg::K_ERROR;
        fr_mode = ltt_pkg::M_IDLE;
        if (!ltt_pkg::is_space(b))
        begin
            case (b)
                ltt_pkg::CH_BSLASH: begin fr_emit = 1'b1; fr_kind = ltt_pkg::K_LAMBDA; end
                ltt_pkg::CH_DOT:    begin fr_emit = 1'b1; fr_kind = ltt_pkg::K_DOT; end
                ltt_pkg::CH_COLON:  begin fr_emit = 1'b1; fr_kind = ltt_pkg::K_COLON; end
                ltt_pkg::CH_LPAREN: begin fr_emit = 1'b1; fr_kind = ltt_pkg::K_LPAREN; end
                ltt_pkg::CH_RPAREN: begin fr_emit = 1'b1; fr_kind = ltt_pkg::K_RPAREN; end
                ltt_pkg::CH_STAR:   begin fr_emit = 1'b1; fr_kind = ltt_pkg::K_STAR; end
                ltt_pkg::CH_DASH:   fr_mode = ltt_pkg::M_DASH;
                ltt_pkg::B_CE:      fr_mode = ltt_pkg::M_CE;
                ltt_pkg::B_E2:      fr_mode = ltt_pkg::M_E2;
                default:
                begin
                    if (ltt_pkg::is_alpha(b) || b == ltt_pkg::CH_UNDER)
                    begin
                        fr_mode = ltt_pkg::M_IDENT;
                    end
                    else
                    begin
                        fr_emit = 1'b1;
                        fr_kind = ltt_pkg::K_ERROR;
                        fr_mode = ltt_pkg::M_ERROR;
                    end
                end
            endcase
        end
    end

    // Next state and the tokens caused by the current beat.
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        count_next  = count_reg;
        prefix_next = prefix_reg;
        do_fresh    = 1'b0;
        has_a       = 1'b0;
        has_b       = 1'b0;
        tok_a       = mk_tok(ltt_pkg::K_ERROR, begin_reg, 7'd1);
        tok_b       = mk_tok(ltt_pkg::K_EOF, pos_reg, 7'd0);

        if (at_end)
        begin
            if (mode_reg == ltt_pkg::M_IDENT)
            begin
                has_a = 1'b1;
                tok_a = mk_tok(ltt_pkg::keyword_kind(prefix_reg, count_reg),
                               begin_reg, count_reg);
            end
            else if (mode_reg != ltt_pkg::M_IDLE && mode_reg != ltt_pkg::M_ERROR)
            begin
                has_a = 1'b1;
            end
            has_b       = 1'b1;
            mode_next   = ltt_pkg::M_IDLE;
            pos_next    = '0;
            begin_next  = '0;
            count_next  = '0;
            prefix_next = '0;
        end
        else
        begin
            case (mode_reg)
                ltt_pkg::M_IDLE:
                begin
                    do_fresh = 1'b1;
                end
                ltt_pkg::M_IDENT:
                begin
                    if (ltt_pkg::is_ident_more(b))
                    begin
                        for (int i = 0; i < ltt_pkg::IDENT_PREFIX_BYTES; i++)
                        begin
                            if (count_reg == 7'(i))
                            begin
                                prefix_next[8*i +: 8] = b;
                            end
                        end
                        if (count_reg < 7'(ltt_pkg::MAX_IDENT_LENGTH))
                        begin
                            count_next = count_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        has_a    = 1'b1;
                        tok_a    = mk_tok(ltt_pkg::keyword_kind(prefix_reg, count_reg),
                                          begin_reg, count_reg);
                        do_fresh = 1'b1;
                    end
                end
                ltt_pkg::M_CE:
                begin
                    has_a     = 1'b1;
                    mode_next = ltt_pkg::M_IDLE;
                    if (b == ltt_pkg::B_BB)
                        tok_a = mk_tok(ltt_pkg::K_LAMBDA, begin_reg, 7'd2);
                    else if (b == ltt_pkg::B_A0)
                        tok_a = mk_tok(ltt_pkg::K_PI, begin_reg, 7'd2);
                    else
                        mode_next = ltt_pkg::M_ERROR;
                end
                ltt_pkg::M_E2:
                begin
                    if (b == ltt_pkg::B_98)
                        mode_next = ltt_pkg::M_E2_98;
                    else if (b == ltt_pkg::B_96)
                        mode_next = ltt_pkg::M_E2_96;
                    else if (b == ltt_pkg::B_86)
                        mode_next = ltt_pkg::M_E2_86;
                    else
                    begin
                        has_a     = 1'b1;
                        mode_next = ltt_pkg::M_ERROR;
                    end
                end
                ltt_pkg::M_E2_98:
                begin
                    has_a     = 1'b1;
                    mode_next = ltt_pkg::M_IDLE;
                    if (b == ltt_pkg::B_85)
                        tok_a = mk_tok(ltt_pkg::K_STAR, begin_reg, 7'd3);
                    else
                        mode_next = ltt_pkg::M_ERROR;
                end
                ltt_pkg::M_E2_96:
                begin
                    has_a     = 1'b1;
                    mode_next = ltt_pkg::M_IDLE;
                    if (b == ltt_pkg::B_A1)
                        tok_a = mk_tok(ltt_pkg::K_BOX, begin_reg, 7'd3);
                    else
                        mode_next = ltt_pkg::M_ERROR;
                end
                ltt_pkg::M_E2_86:
                begin
                    has_a     = 1'b1;
                    mode_next = ltt_pkg::M_IDLE;
                    if (b == ltt_pkg::B_92)
                        tok_a = mk_tok(ltt_pkg::K_ARROW, begin_reg, 7'd3);
                    else
                        mode_next = ltt_pkg::M_ERROR;
                end
                ltt_pkg::M_DASH:
                begin
                    has_a     = 1'b1;
                    mode_next = ltt_pkg::M_IDLE;
                    if (b == ltt_pkg::CH_GT)
                        tok_a = mk_tok(ltt_pkg::K_ARROW, begin_reg, 7'd2);
                    else
                        mode_next = ltt_pkg::M_ERROR;
                end
                default:
                begin
                    mode_next = ltt_pkg::M_ERROR;
                end
            endcase

            // A new token starts at this byte.
            if (do_fresh)
            begin
                mode_next  = fr_mode;
                begin_next = pos_reg;
                has_b      = fr_emit;
                tok_b      = mk_tok(fr_kind, pos_reg, 7'd1);
                if (fr_mode == ltt_pkg::M_IDENT)
                begin
                    count_next  = 7'd1;
                    prefix_next = ltt_pkg::PREFIX_W'(b);
                end
            end

            pos_next = pos_reg + 1'b1;
        end
    end

    // Pack the tokens so the first slot always holds one.
    always_comb
    begin
        push_run.first  = has_a ? tok_a : tok_b;
        push_run.second = tok_b;
        push_run.two    = has_a && has_b;
    end

    assign push = fire && (has_a || has_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ltt_pkg::M_IDLE;
            pos_reg    <= '0;
            begin_reg  <= '0;
            count_reg  <= '0;
            prefix_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            count_reg  <= count_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ----- sv/ltt_queue.sv -----
module ltt_queue #(
    parameter int DEPTH = ltt_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ltt_pkg::token_run_t push_run,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ltt_pkg::token_run_t head_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ltt_pkg::token_run_t entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_run   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_run;
    end

endmodule

// ----- sv/ltt_back.sv -----
module ltt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ltt_pkg::token_run_t head_run,
    output logic                pop,
    ltt_token_if.source         tokens
);

    ltt_pkg::token_run_t run_reg;
    logic                valid_reg, valid_next;
    logic                sub_reg, sub_next;
    logic                is_last;
    logic                fire;
    ltt_pkg::token_t     cur;

    assign cur     = sub_reg ? run_reg.second : run_reg.first;
    assign is_last = sub_reg || !run_reg.two;
    assign fire    = valid_reg && tokens.ready;
    assign pop     = head_valid && (!valid_reg || (fire && is_last));

    assign tokens.valid        = valid_reg;
    assign tokens.token_kind   = ltt_pkg::KIND_W'(cur.kind);
    assign tokens.token_start  = cur.start;
    assign tokens.token_length = cur.length;
    assign tokens.last_of_run  = is_last;

    // Step through the run, then refill from the queue.
    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            sub_next   = 1'b0;
        end
        else if (fire)
        begin
            if (is_last)
                valid_next = 1'b0;
            else
                sub_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            run_reg <= head_run;
    end

endmodule

// ----- sv/lambda_term_tokenizer_unit.sv -----
// Channel   Direction  Beat carries
// text      in         text_byte, end_of_text (one source byte or end of text)
// tokens    out        token_kind, token_start, token_length, last_of_run
//
// One text byte is accepted per cycle unless the queue is full; the scanner state is registered.
// A byte gives zero, one or two tokens; the sender puts out one token per cycle while
// tokens.ready is high, so a byte that gives two tokens sends them one after the other.
// A short queue between scanner and sender absorbs output stalls; text.ready
// drops only when that queue is full. Reset clears mode, position and the queue.
module lambda_term_tokenizer_unit #(
    parameter int POSITION_BITS = ltt_pkg::POSITION_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ltt_text_if.sink     text,
    ltt_token_if.source  tokens
);

    logic                queue_full;
    logic                push;
    ltt_pkg::token_run_t push_run;
    logic                pop;
    logic                head_valid;
    ltt_pkg::token_run_t head_run;

    ltt_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .queue_full (queue_full),
        .push       (push),
        .push_run   (push_run)
    );

    ltt_queue #(
        .DEPTH (ltt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_run   (head_run)
    );

    ltt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_run   (head_run),
        .pop        (pop),
        .tokens     (tokens)
    );

endmodule

// ----- sv/ltt_checker.sv -----
module ltt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [ltt_pkg::KIND_W-1:0]     out_kind,
    input logic [ltt_pkg::START_W-1:0]    out_start,
    input logic [ltt_pkg::LENGTH_W-1:0]   out_length,
    input logic                           out_last
);

    // End of text always closes its run with an empty token.
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == ltt_pkg::KIND_W'(ltt_pkg::K_EOF)
        |-> out_last && out_length == '0)
    else $error("eof token must be last of run with zero length");

    // Error tokens always cover a single byte.
    a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == ltt_pkg::KIND_W'(ltt_pkg::K_ERROR)
        |-> out_length == 7'd1)
    else $error("error token length must be one");

    // Identifiers are never empty.
    a_ident_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == ltt_pkg::KIND_W'(ltt_pkg::K_IDENT)
        |-> out_length != '0)
    else $error("identifier token with zero length");

    // A stalled token holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(out_kind) && $stable(out_start)
            && $stable(out_length) && $stable(out_last))
    else $error("stalled token changed");

endmodule

bind lambda_term_tokenizer_unit ltt_checker u_ltt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .out_kind   (tokens.token_kind),
    .out_start  (tokens.token_start),
    .out_length (tokens.token_length),
    .out_last   (tokens.last_of_run)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // One text beat as queued for the driver.
    typedef struct {
        logic [7:0] text_byte;
        logic       end_of_text;
        bit         paced;
    } text_beat_t;

    // One token as the scanner should produce it.
    typedef struct {
        ltt_pkg::token_kind_t         kind;
        logic [ltt_pkg::START_W-1:0]  start;
        logic [ltt_pkg::LENGTH_W-1:0] length;
        logic                         last;
    } token_exp_t;

    logic clk;
    logic rst_n;

    ltt_text_if  text();
    ltt_token_if tokens();

    lambda_term_tokenizer_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .tokens (tokens)
    );

    string                keyword_text [9] = '{"true", "false", "Bool", "if", "then", "else",
                                               "Pi", "Box", "BOX"};
    ltt_pkg::token_kind_t keyword_kinds [9] = '{ltt_pkg::K_TRUE, ltt_pkg::K_FALSE,
                                                ltt_pkg::K_BOOL, ltt_pkg::K_IF,
                                                ltt_pkg::K_THEN, ltt_pkg::K_ELSE,
                                                ltt_pkg::K_PI, ltt_pkg::K_BOX,
                                                ltt_pkg::K_BOX};

    text_beat_t pending_beats [$];
    token_exp_t expected_tokens [$];
    int         total_beats;
    int         bytes_taken;
    int         token_errors;
    int         send_gap;
    int         send_calm;
    int         recv_gap;
    int         recv_calm;

    // Scanner state as predicted from the accepted bytes.
    ltt_pkg::scan_mode_t          scan_state;
    logic [ltt_pkg::START_W-1:0]  scan_pos;
    logic [ltt_pkg::START_W-1:0]  scan_begin;
    logic [ltt_pkg::LENGTH_W-1:0] word_len;
    logic [ltt_pkg::PREFIX_W-1:0] word_head;

    // Character classes of the token grammar.
    function automatic bit is_blank(logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic bit is_word_char(logic [7:0] b);
        return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || b == ltt_pkg::CH_UNDER
            || b == ltt_pkg::CH_QUOTE;
    endfunction

    function automatic logic [ltt_pkg::PREFIX_W-1:0] pack_head(string w);
        logic [ltt_pkg::PREFIX_W-1:0] v;
        v = '0;
        for (int i = 0; i < w.len() && i < ltt_pkg::IDENT_PREFIX_BYTES; i++)
            v[8*i +: 8] = w[i];
        return v;
    endfunction

    // An identifier becomes a keyword only on an exact length and head match.
    function automatic ltt_pkg::token_kind_t word_kind(logic [ltt_pkg::PREFIX_W-1:0] head,
                                                       logic [ltt_pkg::LENGTH_W-1:0] len);
        for (int i = 0; i < 9; i++)
            if (len == keyword_text[i].len() && head == pack_head(keyword_text[i]))
                return keyword_kinds[i];
        return ltt_pkg::K_IDENT;
    endfunction

    task automatic clear_scanner();
        scan_state = ltt_pkg::M_IDLE;
        scan_pos   = '0;
        scan_begin = '0;
        word_len   = '0;
        word_head  = '0;
    endtask

    task automatic push_token(ltt_pkg::token_kind_t k, logic [ltt_pkg::START_W-1:0] s,
                              logic [ltt_pkg::LENGTH_W-1:0] len);
        token_exp_t t;
        t.kind   = k;
        t.start  = s;
        t.length = len;
        t.last   = 1'b0;
        expected_tokens.push_back(t);
    endtask

    task automatic flag_bad_token();
        push_token(ltt_pkg::K_ERROR, scan_begin, 7'd1);
        scan_state = ltt_pkg::M_ERROR;
    endtask

    task automatic close_token(ltt_pkg::token_kind_t k, logic [ltt_pkg::LENGTH_W-1:0] len);
        push_token(k, scan_begin, len);
        scan_state = ltt_pkg::M_IDLE;
    endtask

    // A byte seen with no token in progress.
    task automatic start_token(logic [7:0] b);
        scan_state = ltt_pkg::M_IDLE;
        scan_begin = scan_pos;
        if (is_blank(b))
            return;
        case (b)
            ltt_pkg::CH_BSLASH: push_token(ltt_pkg::K_LAMBDA, scan_pos, 7'd1);
            ltt_pkg::CH_DOT:    push_token(ltt_pkg::K_DOT, scan_pos, 7'd1);
            ltt_pkg::CH_COLON:  push_token(ltt_pkg::K_COLON, scan_pos, 7'd1);
            ltt_pkg::CH_LPAREN: push_token(ltt_pkg::K_LPAREN, scan_pos, 7'd1);
            ltt_pkg::CH_RPAREN: push_token(ltt_pkg::K_RPAREN, scan_pos, 7'd1);
            ltt_pkg::CH_STAR:   push_token(ltt_pkg::K_STAR, scan_pos, 7'd1);
            ltt_pkg::CH_DASH:   scan_state = ltt_pkg::M_DASH;
            ltt_pkg::B_CE:      scan_state = ltt_pkg::M_CE;
            ltt_pkg::B_E2:      scan_state = ltt_pkg::M_E2;
            default:
            begin
                if (is_letter(b) || b == ltt_pkg::CH_UNDER)
                begin
                    scan_state = ltt_pkg::M_IDENT;
                    word_len   = 7'd1;
                    word_head  = {32'd0, b};
                end
                else
                    flag_bad_token();
            end
        endcase
    endtask

    // Works out the tokens caused by one accepted text beat.
    task automatic tokenize_byte(logic [7:0] b, logic eot);
        int count_at_entry;
        count_at_entry = expected_tokens.size();
        if (eot || b == 8'd0)
        begin
            if (scan_state == ltt_pkg::M_IDENT)
                push_token(word_kind(word_head, word_len), scan_begin, word_len);
            else if (scan_state != ltt_pkg::M_IDLE && scan_state != ltt_pkg::M_ERROR)
                push_token(ltt_pkg::K_ERROR, scan_begin, 7'd1);
            push_token(ltt_pkg::K_EOF, scan_pos, 7'd0);
            clear_scanner();
        end
        else
        begin
            case (scan_state)
                ltt_pkg::M_IDLE: start_token(b);
                ltt_pkg::M_IDENT:
                begin
                    if (is_word_char(b))
                    begin
                        if (word_len < ltt_pkg::IDENT_PREFIX_BYTES)
                            word_head[8*word_len +: 8] = b;
                        if (word_len < ltt_pkg::MAX_IDENT_LENGTH)
                            word_len = word_len + 7'd1;
                    end
                    else
                    begin
                        push_token(word_kind(word_head, word_len), scan_begin, word_len);
                        start_token(b);
                    end
                end
                ltt_pkg::M_CE:
                begin
                    if (b == ltt_pkg::B_BB)
                        close_token(ltt_pkg::K_LAMBDA, 7'd2);
                    else if (b == ltt_pkg::B_A0)
                        close_token(ltt_pkg::K_PI, 7'd2);
                    else
                        flag_bad_token();
                end
                ltt_pkg::M_E2:
                begin
                    if (b == ltt_pkg::B_98)
                        scan_state = ltt_pkg::M_E2_98;
                    else if (b == ltt_pkg::B_96)
                        scan_state = ltt_pkg::M_E2_96;
                    else if (b == ltt_pkg::B_86)
                        scan_state = ltt_pkg::M_E2_86;
                    else
                        flag_bad_token();
                end
                ltt_pkg::M_E2_98:
                begin
                    if (b == ltt_pkg::B_85)
                        close_token(ltt_pkg::K_STAR, 7'd3);
                    else
                        flag_bad_token();
                end
                ltt_pkg::M_E2_96:
                begin
                    if (b == ltt_pkg::B_A1)
                        close_token(ltt_pkg::K_BOX, 7'd3);
                    else
                        flag_bad_token();
                end
                ltt_pkg::M_E2_86:
                begin
                    if (b == ltt_pkg::B_92)
                        close_token(ltt_pkg::K_ARROW, 7'd3);
                    else
                        flag_bad_token();
                end
                ltt_pkg::M_DASH:
                begin
                    if (b == ltt_pkg::CH_GT)
                        close_token(ltt_pkg::K_ARROW, 7'd2);
                    else
                        flag_bad_token();
                end
                default: scan_state = ltt_pkg::M_ERROR;
            endcase
            scan_pos = scan_pos + 1'b1;
        end
        if (expected_tokens.size() > count_at_entry)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    // Mostly no gap, sometimes short, rarely long, with calm stretches between.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(999);
        if (r < 8)
        begin
            calm = $urandom_range(200, 60);
            return 0;
        end
        if (r < 600)
            return 0;
        if (r < 950)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Stimulus building blocks.
    task automatic add_beat(logic [7:0] b, logic eot, bit paced);
        text_beat_t t;
        t.text_byte   = b;
        t.end_of_text = eot;
        t.paced       = paced;
        pending_beats.push_back(t);
    endtask

    task automatic add_byte(logic [7:0] b);
        add_beat(b, 1'b0, 1'b1);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_end();
        if ($urandom_range(1) == 1)
            add_beat(8'($urandom_range(255)), 1'b1, 1'b1);
        else
            add_beat(8'd0, 1'b0, 1'b1);
    endtask

    function automatic logic [7:0] blank_char();
        int v;
        v = $urandom_range(5);
        return (v == 5) ? 8'd32 : 8'(9 + v);
    endfunction

    function automatic logic [7:0] first_char();
        int r;
        r = $urandom_range(52);
        if (r == 52)
            return ltt_pkg::CH_UNDER;
        return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(63);
        if (r < 52)
            return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
        if (r < 62)
            return 8'(8'h30 + r - 52);
        return (r == 62) ? ltt_pkg::CH_UNDER : ltt_pkg::CH_QUOTE;
    endfunction

    // Builds one text of mostly well-formed tokens, some noise, closed by an end.
    task automatic add_random_text();
        int n_tok;
        int r;
        int len;
        string w;
        n_tok = $urandom_range(12, 1);
        for (int i = 0; i < n_tok; i++)
        begin
            if ($urandom_range(9) < 6)
                add_byte(blank_char());
            r = $urandom_range(99);
            if (r < 22)
            begin
                // Keywords, some of them one byte too long or too short.
                w = keyword_text[$urandom_range(8)];
                len = $urandom_range(9);
                if (len == 0)
                    w = w.substr(0, w.len() - 2);
                add_text(w);
                if (len > 6)
                    add_byte(word_char());
            end
            else if (r < 42)
            begin
                add_byte(first_char());
                len = ($urandom_range(29) == 0) ? $urandom_range(135, 118)
                                                : $urandom_range(8, 0);
                repeat (len) add_byte(word_char());
            end
            else if (r < 62)
            begin
                case ($urandom_range(5))
                    0: add_byte(ltt_pkg::CH_BSLASH);
                    1: add_byte(ltt_pkg::CH_DOT);
                    2: add_byte(ltt_pkg::CH_COLON);
                    3: add_byte(ltt_pkg::CH_LPAREN);
                    4: add_byte(ltt_pkg::CH_RPAREN);
                    default: add_byte(ltt_pkg::CH_STAR);
                endcase
            end
            else if (r < 77)
            begin
                case ($urandom_range(4))
                    0: begin add_byte(ltt_pkg::B_CE); add_byte(ltt_pkg::B_BB); end
                    1: begin add_byte(ltt_pkg::B_CE); add_byte(ltt_pkg::B_A0); end
                    2:
                    begin
                        add_byte(ltt_pkg::B_E2); add_byte(ltt_pkg::B_98);
                        add_byte(ltt_pkg::B_85);
                    end
                    3:
                    begin
                        add_byte(ltt_pkg::B_E2); add_byte(ltt_pkg::B_96);
                        add_byte(ltt_pkg::B_A1);
                    end
                    default:
                    begin
                        add_byte(ltt_pkg::B_E2); add_byte(ltt_pkg::B_86);
                        add_byte(ltt_pkg::B_92);
                    end
                endcase
            end
            else if (r < 85)
            begin
                add_byte(ltt_pkg::CH_DASH);
                add_byte(ltt_pkg::CH_GT);
            end
            else if (r < 89)
            begin
                // Sequence that breaks off on an arbitrary byte.
                case ($urandom_range(3))
                    0: add_byte(ltt_pkg::B_CE);
                    1: add_byte(ltt_pkg::B_E2);
                    2:
                    begin
                        add_byte(ltt_pkg::B_E2);
                        add_byte($urandom_range(1) ? ltt_pkg::B_96 : ltt_pkg::B_86);
                    end
                    default: add_byte(ltt_pkg::CH_DASH);
                endcase
                add_byte(8'($urandom_range(255)));
            end
            else if (r < 92)
                add_byte(8'($urandom_range(255, 1)));
            else if (r < 95)
            begin
                // Unfinished sequence cut by the end of the text.
                case ($urandom_range(3))
                    0: add_byte(ltt_pkg::B_CE);
                    1: add_byte(ltt_pkg::B_E2);
                    2: begin add_byte(ltt_pkg::B_E2); add_byte(ltt_pkg::B_98); end
                    default: add_byte(ltt_pkg::CH_DASH);
                endcase
                break;
            end
            else
                repeat ($urandom_range(4, 1)) add_byte(blank_char());
        end
        add_end();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Driver: offers the queued text beats, with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t nxt;
        if (!rst_n)
        begin
            text.valid       <= 1'b0;
            text.text_byte   <= '0;
            text.end_of_text <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                tokenize_byte(text.text_byte, text.end_of_text);
                bytes_taken++;
            end
            if (!text.valid || text.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    text.valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    nxt = pending_beats.pop_front();
                    text.valid       <= 1'b1;
                    text.text_byte   <= nxt.text_byte;
                    text.end_of_text <= nxt.end_of_text;
                    if (nxt.paced)
                        send_gap = pick_gap(send_calm);
                end
                else
                    text.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each token beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        token_exp_t want;
        if (!rst_n)
        begin
            tokens.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (tokens.valid && tokens.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    token_errors++;
                    if (token_errors <= 10)
                        $display("%0t: unexpected token kind %0d start %0d length %0d last %0b",
                                 $time, tokens.token_kind, tokens.token_start,
                                 tokens.token_length, tokens.last_of_run);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (tokens.token_kind !== want.kind || tokens.token_start !== want.start
                        || tokens.token_length !== want.length
                        || tokens.last_of_run !== want.last)
                    begin
                        token_errors++;
                        if (token_errors <= 10)
                            $display({"%0t: token mismatch: expected kind %0d start %0d ",
                                      "length %0d last %0b, got kind %0d start %0d ",
                                      "length %0d last %0b"},
                                     $time, want.kind, want.start, want.length, want.last,
                                     tokens.token_kind, tokens.token_start,
                                     tokens.token_length, tokens.last_of_run);
                    end
                end
                recv_gap = pick_gap(recv_calm);
            end
            else if (!tokens.valid && recv_gap == 0 && $urandom_range(15) == 0)
                recv_gap = pick_gap(recv_calm);
            if (recv_gap > 0)
            begin
                recv_gap--;
                tokens.ready <= 1'b0;
            end
            else
                tokens.ready <= 1'b1;
        end
    end

    initial
    begin
        int random_items;
        rst_n        = 1'b0;
        bytes_taken  = 0;
        token_errors = 0;
        send_calm    = 0;
        recv_calm    = 0;
        clear_scanner();

        // Directed text: every symbol token form, the keyword if, an identifier ended by punctuation,
        // a bad byte followed by ignored bytes, then end flags of both kinds.
        add_byte(ltt_pkg::B_CE); add_byte(ltt_pkg::B_BB);
        add_text("x.");
        add_byte(ltt_pkg::B_E2); add_byte(ltt_pkg::B_98); add_byte(ltt_pkg::B_85);
        add_byte(ltt_pkg::B_E2); add_byte(ltt_pkg::B_96); add_byte(ltt_pkg::B_A1);
        add_byte(ltt_pkg::B_E2); add_byte(ltt_pkg::B_86); add_byte(ltt_pkg::B_92);
        add_text("->:()*");
        add_byte(ltt_pkg::CH_BSLASH);
        add_byte(ltt_pkg::B_CE); add_byte(ltt_pkg::B_A0);
        add_text(" q'");
        add_byte(8'hFF);
        add_text("a");
        add_beat(8'h41, 1'b1, 1'b1);
        add_text("if");
        add_beat(8'd0, 1'b0, 1'b1);

        // Random texts.
        random_items = pending_beats.size();
        while (pending_beats.size() - random_items < 1400)
            add_random_text();
        total_beats = pending_beats.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != total_beats)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (token_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
